FILE: src/md5_pkg.sv
// MD5 package: shared types, constants and round tables.
// No dependencies.
package md5_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } md5_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md5_out_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int          QUEUE_DEPTH = 2;

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
            4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
            4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] word_sel(input logic [5:0] r);
        logic [3:0] g;
        unique case (r[5:4])
            2'd0: g = r[3:0];
            2'd1: g = 4'(5 * r[3:0] + 1);
            2'd2: g = 4'(3 * r[3:0] + 5);
            default: g = 4'(7 * r[3:0]);
        endcase
        return g;
    endfunction
endpackage

FILE: src/md5_stream_if.sv
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing; payload type set by parameter.
interface md5_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: src/md5_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

FILE: src/md5_front.sv
// Front end: accepts requests, drops empty ones, queues them for the core.
// Depends on md5_pkg and md5_stream_if.
module md5_front (
    input  logic clk,
    input  logic rst_n,
    md5_stream_if.sink   in_ch,
    output md5_pkg::md5_in_t q_data,
    output logic         q_valid,
    input  logic         q_pop
);
    import md5_pkg::*;

    md5_in_t    fifo_reg [QUEUE_DEPTH];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push = in_ch.valid && in_ch.ready
                  && (in_ch.payload.has_byte || in_ch.payload.end_of_message);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = fifo_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (q_pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wp_reg] <= in_ch.payload;
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QUEUE_DEPTH))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count slip");
endmodule

FILE: src/md5_core.sv
// Back end: block buffer, padding, 64-round compression, digest output.
// Depends on md5_pkg, md5_ram and md5_stream_if.
module md5_core (
    input  logic clk,
    input  logic rst_n,
    input  md5_pkg::md5_in_t q_data,
    input  logic         q_valid,
    output logic         q_pop,
    md5_stream_if.source out_ch
);
    import md5_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_FOLD, S_OUT} state_t;

    state_t      state_reg;
    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic [5:0]  pos_reg;
    logic [5:0]  rnd_reg;
    logic        closing_reg;
    logic [1:0]  oi_reg;
    logic        ovalid_reg;
    logic [3:0]  wwa_reg;
    logic [31:0] wacc_reg;

    // word RAM: 16 words of 32 bits, one byte lane assembled before write
    logic        we;
    logic [3:0]  waddr;
    logic [31:0] wdata;
    logic [3:0]  raddr;
    logic [31:0] rdata;
    logic [7:0]  wbyte;
    logic        wr_byte;
    logic [31:0] f, t, sum, rot;
    logic [5:0]  rnext;

    md5_ram #(.WIDTH(32), .DEPTH(16)) u_words (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        unique case (pos_reg[1:0])
            2'd0: wdata = {24'd0, wbyte};
            2'd1: wdata = {16'd0, wbyte, wacc_reg[7:0]};
            2'd2: wdata = {8'd0, wbyte, wacc_reg[15:0]};
            default: wdata = {wbyte, wacc_reg[23:0]};
        endcase
    end
    assign waddr = pos_reg[5:2];
    assign we    = wr_byte;

    // wwa_reg[1]: current padding block carries the length
    always_comb
    begin
        wr_byte = 1'b0;
        wbyte   = q_data.data_byte;
        q_pop   = 1'b0;
        if (state_reg == S_IDLE && q_valid)
        begin
            wr_byte = q_data.has_byte;
            q_pop   = 1'b1;
        end
        else if (state_reg == S_PAD)
        begin
            wr_byte = 1'b1;
            if (!closing_reg)
                wbyte = PAD_BYTE;
            else if (wwa_reg[1] && pos_reg >= 6'd56)
                wbyte = len_reg[8 * pos_reg[2:0] +: 8];
            else
                wbyte = 8'd0;
        end
    end

    assign rnext = rnd_reg + 6'd1;
    assign raddr = (state_reg == S_ROUND && wwa_reg[3]) ? word_sel(rnext) : 4'd0;

    always_comb
    begin
        unique case (rnd_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        t   = a_reg + f + rdata + round_const(rnd_reg);
        rot = (t << rot_amount(rnd_reg)) | (t >> (6'd32 - {1'b0, rot_amount(rnd_reg)}));
        sum = b_reg + rot;
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.payload.digest_word = h_reg[oi_reg];
    assign out_ch.payload.word_index  = oi_reg;
    assign out_ch.payload.last_word   = (oi_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            h_reg[0]    <= INIT_A;
            h_reg[1]    <= INIT_B;
            h_reg[2]    <= INIT_C;
            h_reg[3]    <= INIT_D;
            a_reg       <= 32'd0;
            b_reg       <= 32'd0;
            c_reg       <= 32'd0;
            d_reg       <= 32'd0;
            bits_reg    <= 64'd0;
            pos_reg     <= 6'd0;
            rnd_reg     <= 6'd0;
            closing_reg <= 1'b0;
            oi_reg      <= 2'd0;
            ovalid_reg  <= 1'b0;
            wacc_reg    <= 32'd0;
            len_reg     <= 64'd0;
            wwa_reg     <= 4'd0;
        end
        else
        begin
            if (wr_byte)
                wacc_reg <= wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        priority if (q_data.has_byte)
                        begin
                            bits_reg <= bits_reg + 64'd8;
                            pos_reg  <= pos_reg + 6'd1;
                            if (q_data.end_of_message)
                            begin
                                len_reg     <= bits_reg + 64'd8;
                                closing_reg <= 1'b0;
                                state_reg   <= (pos_reg == 6'd63) ? S_ROUND : S_PAD;
                            end
                            else if (pos_reg == 6'd63)
                                state_reg <= S_ROUND;
                        end
                        else
                        begin
                            len_reg     <= bits_reg;
                            closing_reg <= 1'b0;
                            state_reg   <= S_PAD;
                        end
                        if (q_data.end_of_message)
                            wwa_reg <= 4'd1;
                        else
                            wwa_reg <= 4'd0;
                        rnd_reg <= 6'd0;
                        a_reg <= h_reg[0]; b_reg <= h_reg[1];
                        c_reg <= h_reg[2]; d_reg <= h_reg[3];
                    end
                end
                S_PAD:
                begin
                    closing_reg <= 1'b1;
                    if (!closing_reg)
                        wwa_reg[1] <= (pos_reg < 6'd56);
                    pos_reg     <= pos_reg + 6'd1;
                    rnd_reg     <= 6'd0;
                    a_reg <= h_reg[0]; b_reg <= h_reg[1];
                    c_reg <= h_reg[2]; d_reg <= h_reg[3];
                    if (pos_reg == 6'd63)
                        state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    // first cycle only primes the RAM read of word 0
                    if (wwa_reg[3])
                    begin
                        a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg; b_reg <= sum;
                        rnd_reg <= rnext;
                        if (rnd_reg == 6'd63)
                            state_reg <= S_FOLD;
                    end
                    wwa_reg[3] <= 1'b1;
                end
                S_FOLD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    wwa_reg[3] <= 1'b0;
                    if (!wwa_reg[0])
                        state_reg <= S_IDLE;
                    else if (closing_reg && wwa_reg[1])
                    begin
                        state_reg  <= S_OUT;
                        ovalid_reg <= 1'b1;
                        oi_reg     <= 2'd0;
                    end
                    else
                    begin
                        state_reg <= S_PAD;
                        if (closing_reg)
                            wwa_reg[1] <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        oi_reg <= oi_reg + 2'd1;
                        if (oi_reg == 2'd3)
                        begin
                            ovalid_reg  <= 1'b0;
                            state_reg   <= S_IDLE;
                            h_reg[0]    <= INIT_A;
                            h_reg[1]    <= INIT_B;
                            h_reg[2]    <= INIT_C;
                            h_reg[3]    <= INIT_D;
                            bits_reg    <= 64'd0;
                            pos_reg     <= 6'd0;
                            closing_reg <= 1'b0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> state_reg == S_OUT)
        else $error("digest shown outside output phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE)
        else $error("request taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.payload.last_word) |=> pos_reg == 6'd0)
        else $error("state not restarted after digest");
endmodule

FILE: src/md5_message_digest.sv
// Streaming MD5 hasher top level; depends on md5_pkg, md5_stream_if, md5_front, md5_core.
// Throughput: one byte request per cycle while the core is idle; a full block then
// stalls intake (RAM prime, 64 rounds, fold) while the two-entry queue absorbs input.
// Closing pads one byte per cycle (one or two blocks, each compressed), then shows
// four digest words, one per cycle while ready; requests are queued before the core.
// Reset (rst_n, async, low) loads the MD5 initial values and clears the count.
module md5_message_digest (
    input  logic clk,
    input  logic rst_n,
    md5_stream_if.sink   in_ch,
    md5_stream_if.source out_ch
);
    import md5_pkg::*;

    md5_in_t q_data;
    logic    q_valid;
    logic    q_pop;

    md5_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
    );

    md5_core u_core (
        .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid),
        .q_pop(q_pop), .out_ch(out_ch)
    );
endmodule

FILE: tb/tb_md5_message_digest.sv
// Testbench for md5_message_digest: streams byte requests, predicts MD5 digests
// with a behavioral hasher and checks each digest word in order.
// Depends on md5_pkg, md5_stream_if and the md5_message_digest RTL.
`timescale 1ns / 1ps

module tb_md5_message_digest;
    import md5_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    md5_stream_if #(.payload_t(md5_in_t))  in_ch ();
    md5_stream_if #(.payload_t(md5_out_t)) out_ch ();

    md5_message_digest u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #2 clk = ~clk;

    // hasher state
    logic [31:0] hash_words [4];
    logic [63:0] msg_bits;
    logic [7:0]  blk_bytes [64];

    md5_in_t  pending_reqs [$];
    md5_out_t digest_queue [$];

    int cycle_count = 0;
    int mismatches = 0;
    int accepted_reqs = 0;
    int digests_seen = 0;
    int messages_closed = 0;
    bit start_hold = 1'b0;
    logic hold_active = 1'b0;
    bit pause_sender = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        int g;
        int shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        logic [31:0] kc [64] = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
            32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
            32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
            32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
            32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
            32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
        for (int r = 0; r < 64; r++)
        begin
            case (r / 16)
                0: begin f = (b & c) | (~b & d); g = r; end
                1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
            endcase
            t = a + f + w[g] + kc[r];
            a = d; d = c; c = b;
            b = b + rotl(t, shifts[(r / 16) * 4 + r % 4]);
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
    endtask

    task automatic absorb_byte(inout int pos, input logic [7:0] v);
        blk_bytes[pos] = v;
        pos = (pos + 1) % 64;
        if (pos == 0)
            compress_block();
    endtask

    task automatic restart_hash();
        hash_words[0] = INIT_A; hash_words[1] = INIT_B;
        hash_words[2] = INIT_C; hash_words[3] = INIT_D;
        msg_bits = '0;
    endtask

    task automatic predict_digest(input md5_in_t req);
        int pos;
        logic [63:0] len;
        md5_out_t res;
        pos = int'(msg_bits[8:3]);
        if (req.has_byte)
        begin
            absorb_byte(pos, req.data_byte);
            msg_bits += 64'd8;
        end
        if (req.end_of_message)
        begin
            len = msg_bits;
            absorb_byte(pos, PAD_BYTE);
            while (pos != 56)
                absorb_byte(pos, 8'h00);
            for (int k = 0; k < 8; k++)
                absorb_byte(pos, len[8*k +: 8]);
            for (int k = 0; k < 4; k++)
            begin
                res.digest_word = hash_words[k];
                res.word_index = 2'(k);
                res.last_word = (k == 3);
                digest_queue.push_back(res);
            end
            messages_closed++;
            restart_hash();
        end
    endtask

    function automatic md5_in_t make_req(input logic [7:0] b, input bit hb, input bit eom);
        md5_in_t r;
        r.data_byte = b; r.has_byte = hb; r.end_of_message = eom;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic add_message(input int nbytes, input bit eom_with_byte);
        for (int i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                pending_reqs.push_back(make_req(8'($urandom), 1'b0, 1'b0));
            pending_reqs.push_back(make_req(8'($urandom), 1'b1,
                                            eom_with_byte && (i == nbytes - 1)));
        end
        if (!eom_with_byte || nbytes == 0)
            pending_reqs.push_back(make_req(8'($urandom), 1'b0, 1'b1));
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // long receiver hold, counted here
    initial
    begin
        wait (start_hold);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (400) @(posedge clk);
        hold_active <= 1'b0;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.payload <= '0;
            restart_hash();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_digest(in_ch.payload);
                accepted_reqs++;
                void'(pending_reqs.pop_front());
                send_gap = pick_gap();
            end
            if (in_ch.valid && !in_ch.ready)
                ;
            else if (send_gap > 0 || pause_sender || pending_reqs.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                in_ch.valid <= 1'b0;
            end
            else
            begin
                in_ch.valid <= 1'b1;
                in_ch.payload <= pending_reqs[0];
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        md5_out_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                digests_seen++;
                if (digest_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest word %h", out_ch.payload);
                end
                else
                begin
                    want = digest_queue.pop_front();
                    if (out_ch.payload !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want word %h idx %0d last %0b, got %h %0d %0b",
                                     want.digest_word, want.word_index, want.last_word,
                                     out_ch.payload.digest_word, out_ch.payload.word_index,
                                     out_ch.payload.last_word);
                    end
                end
                recv_gap = pick_gap();
            end
            if (hold_active)
                out_ch.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, idle item, extremes, padding boundaries
        add_message(0, 1'b0);
        pending_reqs.push_back(make_req(8'hff, 1'b0, 1'b0));
        pending_reqs.push_back(make_req(8'hff, 1'b1, 1'b1));
        pending_reqs.push_back(make_req(8'h00, 1'b1, 1'b0));
        pending_reqs.push_back(make_req(8'h00, 1'b0, 1'b1));
        add_message(3, 1'b1);
        wait (pending_reqs.size() == 0 && digest_queue.size() == 0);
        add_message(55, 1'b1);
        add_message(56, 1'b0);
        // long receiver hold while the sender keeps offering
        start_hold = 1'b1;
        add_message(64, 1'b1);
        add_message(2, 1'b0);
        add_message(1, 1'b1);
        wait (pending_reqs.size() == 0 && digest_queue.size() == 0);

        // sender waits until every digest is back
        add_message(5, 1'b0);
        wait (pending_reqs.size() == 0 && digest_queue.size() == 0);

        // random messages, mostly short
        while (accepted_reqs + pending_reqs.size() < 450)
        begin
            if (pending_reqs.size() < 8)
            begin
                case ($urandom_range(0, 9))
                    0: add_message($urandom_range(54, 130), $urandom_range(0, 1));
                    1: pending_reqs.push_back(make_req(8'($urandom), 1'b0, 1'b0));
                    default: add_message($urandom_range(0, 20), $urandom_range(0, 1));
                endcase
            end
            @(posedge clk);
        end

        wait (pending_reqs.size() == 0 && digest_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests, %0d messages hashed, %0d digest words checked",
                 accepted_reqs, messages_closed, digests_seen);
        if (mismatches == 0 && digest_queue.size() == 0)
            $display("== PASS ==");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
